FILE: rtl/fpbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbh_pkg
// Shared types and constants for the parity bitmap fact hasher.
// ----------------------------------------------------------------------------
package fpbh_pkg;

  localparam int unsigned MAX_IDX_W     = 16;
  localparam int unsigned MIN_IDX_W     = 6;
  localparam int unsigned BM_WORD_BITS  = 64;
  localparam int unsigned BM_BIT_AW     = $clog2(BM_WORD_BITS);
  localparam int unsigned BM_WORDS      = (1 << MAX_IDX_W) / BM_WORD_BITS;
  localparam int unsigned BM_AW         = $clog2(BM_WORDS);
  localparam int unsigned CNT_W         = MAX_IDX_W + 1;

  localparam logic [31:0] HASH_MULT = 32'h6d2a_c891;

  localparam logic [4:0] IDX_W_RST = 5'(MAX_IDX_W);
  localparam logic [4:0] IDX_W_MIN = 5'(MIN_IDX_W);
  localparam logic [4:0] IDX_W_MAX = 5'(MAX_IDX_W);

  typedef enum logic [1:0] {
    ACT_WORD  = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MOD,
    S_CLEAR,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/fact_parity_bitmap_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fact_parity_bitmap_hasher
// Multiplicative fact hash with an XOR parity bitmap held in block memory.
// ----------------------------------------------------------------------------
// A transfer is taken only while idle. An element without last or a query goes
// straight to the result; an element with last first reads its bitmap word, then
// modifies and writes it back, and a clear walks all 1024 bitmap words.
// No new item is taken until the result of the last one has been loaded into
// the output register, which waits for m_tready.
// Reset: a clearing pass empties the bitmap; no stream input is taken then.
module fact_parity_bitmap_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,   // index width
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // value[31:0]
  input  logic [1:0]  s_tuser,    // action[1:0]
  input  logic        s_tlast,    // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata     // clean[0], flipped[1], bit_index[17:2],
                                  // bit_value[18], pad[23:19]
);
  import fpbh_pkg::*;

  state_t state, state_next;

  logic [4:0]               idx_width;
  logic [31:0]              running_hash;
  logic [CNT_W-1:0]         ones_count;
  logic [BM_AW-1:0]         clr_ptr;
  logic                     clr_report;
  logic [MAX_IDX_W-1:0]     idx_q;

  logic                     res_clean;
  logic                     res_flipped;
  logic [MAX_IDX_W-1:0]     res_index;
  logic                     res_bit;

  logic [BM_WORD_BITS-1:0]  mem [BM_WORDS];
  logic [BM_WORD_BITS-1:0]  mem_q;

  logic                     s_fire;
  logic                     out_free;
  logic                     out_load;
  logic                     mem_rd;
  logic                     mem_we;
  logic [BM_AW-1:0]         mem_waddr;
  logic [BM_WORD_BITS-1:0]  mem_wdata;
  logic [BM_WORD_BITS-1:0]  bit_mask;
  logic                     bit_new;
  logic [CNT_W-1:0]         ones_next;
  logic                     clr_done;

  logic [31:0]              elem;
  logic [31:0]              hash_new;
  logic [4:0]               eff_bits;
  logic [MAX_IDX_W:0]       idx_mask;
  logic [MAX_IDX_W-1:0]     idx_new;
  act_t                     act;

  assign cfg_ready = 1'b1;

  assign act      = act_t'(s_tuser);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign clr_done = (clr_ptr == BM_AW'(BM_WORDS - 1));

  // Sign-extend key bytes; words pass as they are.
  assign elem     = (act == ACT_BYTE) ? {{24{s_tdata[7]}}, s_tdata[7:0]} : s_tdata;
  assign hash_new = running_hash * HASH_MULT + elem;

  always_comb begin
    if (idx_width < IDX_W_MIN) begin
      eff_bits = IDX_W_MIN;
    end else if (idx_width > IDX_W_MAX) begin
      eff_bits = IDX_W_MAX;
    end else begin
      eff_bits = idx_width;
    end
  end

  assign idx_mask = ((MAX_IDX_W + 1)'(1) << eff_bits) - (MAX_IDX_W + 1)'(1);
  assign idx_new  = hash_new[MAX_IDX_W-1:0] & idx_mask[MAX_IDX_W-1:0];

  assign bit_mask  = BM_WORD_BITS'(1) << idx_q[BM_BIT_AW-1:0];
  assign bit_new   = ~mem_q[idx_q[BM_BIT_AW-1:0]];
  assign ones_next = bit_new ? ones_count + CNT_W'(1) : ones_count - CNT_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (act)
            ACT_WORD, ACT_BYTE: state_next = s_tlast ? S_READ : S_EMIT;
            ACT_QUERY:          state_next = S_EMIT;
            ACT_CLEAR:          state_next = S_CLEAR;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_READ:  state_next = S_MOD;
      S_MOD:   state_next = S_EMIT;
      S_CLEAR: begin
        if (clr_done) begin
          state_next = clr_report ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready  = 1'b0;
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q[MAX_IDX_W-1:BM_BIT_AW];
    mem_wdata = mem_q ^ bit_mask;
    out_load  = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_READ:  mem_rd = 1'b1;
      S_MOD:   mem_we = 1'b1;
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr;
        mem_wdata = '0;
      end
      S_EMIT:  out_load = out_free;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_width <= IDX_W_RST;
    end else if (cfg_valid && cfg_ready) begin
      idx_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      ones_count   <= '0;
      clr_ptr      <= '0;
      clr_report   <= 1'b0;
    end else begin
      if (s_fire) begin
        case (act)
          ACT_WORD, ACT_BYTE: running_hash <= s_tlast ? '0 : hash_new;
          ACT_CLEAR: begin
            running_hash <= '0;
            clr_report   <= 1'b1;
          end
          default: running_hash <= running_hash;
        endcase
      end
      if (state == S_MOD) begin
        ones_count <= ones_next;
      end
      if (state == S_CLEAR) begin
        clr_ptr <= clr_ptr + BM_AW'(1);
        if (clr_done) begin
          ones_count <= '0;
        end
      end
    end
  end

  // Pending result, held until the output register frees up
  always_ff @(posedge clk) begin
    if (s_fire) begin
      idx_q       <= idx_new;
      res_clean   <= (ones_count == '0);
      res_flipped <= 1'b0;
      res_index   <= '0;
      res_bit     <= 1'b0;
    end
    if (state == S_MOD) begin
      res_clean   <= (ones_next == '0);
      res_flipped <= 1'b1;
      res_index   <= idx_q;
      res_bit     <= bit_new;
    end
    if (state == S_CLEAR && clr_done) begin
      res_clean <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, res_bit, res_index, res_flipped, res_clean};
    end
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      mem_q <= mem[idx_q[MAX_IDX_W-1:BM_BIT_AW]];
    end
  end

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ones_count <= CNT_W'(1 << MAX_IDX_W))
    else $error("set-bit count out of range");

  a_query_keeps_hash: assert property (@(posedge clk) disable iff (rst)
    s_fire && act == ACT_QUERY |=> $stable(running_hash))
    else $error("query changed the running hash");

  a_clear_resets_count: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR && clr_done |=> ones_count == '0)
    else $error("clear did not empty the set-bit count");

  a_no_flip_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[18:2] == '0)
    else $error("index or bit value set on a result without a toggle");

  a_toggle_writes_back: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> mem_we && mem_waddr == idx_q[MAX_IDX_W-1:BM_BIT_AW])
    else $error("bitmap read not followed by write back to the same word");

endmodule
